// ----- design/hfan_pkg.sv -----
// shared types and fixed field widths for the hex face area vector block
package hfan_pkg;

	localparam int FACE_W   = 12;
	localparam int CELLIN_W = 16;
	localparam int SLOT_W   = 3;
	localparam int CORNER_W = 60;
	localparam int NORM_W   = 43;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	typedef struct packed {
		logic        [FACE_W-1:0] face_id;
		logic signed [NORM_W-1:0] nx;
		logic signed [NORM_W-1:0] ny;
		logic signed [NORM_W-1:0] nz;
	} result_t;

endpackage

// ----- design/hex_face_area_normal.sv -----
// hex face owner tracking and area vector (c-a)x(d-b) with one extra bit of headroom for the difference
// a request is registered into stage 1, its products into stage 2, then its result into the queue
// one face per cycle while item_ready is high, with the owner table on a single read-modify-write port
// a 4-entry result queue lets requests keep flowing while the output side stalls
// reset: arst_n clears control state, then a clearing pass walks the owner table,
// one entry per cycle over all MAX_FACES entries, with item_ready held low
module hex_face_area_normal #(
	parameter int MAX_FACES  = 4096,
	parameter int COORD_BITS = 20,
	parameter int CELL_BITS  = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_ready,
	input  logic [hfan_pkg::CORNER_W-1:0]         corner_a,
	input  logic [hfan_pkg::CORNER_W-1:0]         corner_b,
	input  logic [hfan_pkg::CORNER_W-1:0]         corner_c,
	input  logic [hfan_pkg::CORNER_W-1:0]         corner_d,
	input  logic [hfan_pkg::FACE_W-1:0]           face_id,
	input  logic [hfan_pkg::CELLIN_W-1:0]         cell_id,
	input  logic [hfan_pkg::SLOT_W-1:0]           face_slot,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output logic [hfan_pkg::FACE_W-1:0]           out_face_id,
	output logic signed [hfan_pkg::NORM_W-1:0]    normal_x,
	output logic signed [hfan_pkg::NORM_W-1:0]    normal_y,
	output logic signed [hfan_pkg::NORM_W-1:0]    normal_z
);

	localparam int FIDX_W = $clog2(MAX_FACES);
	localparam int IDW    = (FIDX_W > hfan_pkg::FACE_W) ? FIDX_W : hfan_pkg::FACE_W;
	localparam int XW     = (3 * COORD_BITS > hfan_pkg::CORNER_W) ? 3 * COORD_BITS
		: hfan_pkg::CORNER_W;
	localparam int DW     = COORD_BITS + 1;
	localparam int PW     = 2 * DW;
	localparam int NW0    = PW + 1;
	localparam int NW     = (NW0 > hfan_pkg::NORM_W) ? NW0 : hfan_pkg::NORM_W;
	localparam int MW     = CELL_BITS + 1;

	// owner table: top bit is the owner flag, low bits the owning cell
	logic [MW-1:0] owner_mem [MAX_FACES];

	// clearing pass
	logic              clr_q;
	logic [FIDX_W-1:0] clr_idx_q;

	// input side
	logic              in_acc;
	logic [IDW-1:0]    fid_w;
	logic              in_range;
	logic [FIDX_W-1:0] idx;
	logic [XW-1:0]     xa, xb, xc, xd;
	logic signed [DW-1:0] u_in [3];
	logic signed [DW-1:0] v_in [3];

	// stage 1
	logic                       valid_s1;
	logic                       in_range_s1;
	logic                       fwd_s1;
	logic                       neg_s1;
	logic [FIDX_W-1:0]          idx_s1;
	logic [hfan_pkg::FACE_W-1:0] fid_s1;
	logic [CELL_BITS-1:0]       cell_s1;
	logic signed [DW-1:0]       u_s1 [3];
	logic signed [DW-1:0]       v_s1 [3];
	logic [MW-1:0]              mem_rd_s1;
	logic                       owned_s1;
	logic                       wr_s1;

	// stage 2
	logic                       valid_s2;
	logic                       neg_s2;
	logic [hfan_pkg::FACE_W-1:0] fid_s2;
	logic signed [PW-1:0]       p_s2 [6];
	logic signed [NW-1:0]       n_s2 [3];
	hfan_pkg::result_t          res_s2;

	// result queue
	hfan_pkg::result_t              fifo_q [hfan_pkg::FIFO_DEPTH];
	logic [hfan_pkg::FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [hfan_pkg::FIFO_CNT_W-1:0] cnt_q;
	logic [hfan_pkg::FIFO_CNT_W-1:0] reserved;
	logic                           out_acc;

	assign fid_w    = IDW'(face_id);
	// one bit wider so that a power-of-two table size does not wrap to zero
	assign in_range = (IDW+1)'(fid_w) < (IDW+1)'(MAX_FACES);
	assign idx      = fid_w[FIDX_W-1:0];

	// every request in flight has a queue slot reserved
	assign reserved = cnt_q + hfan_pkg::FIFO_CNT_W'(valid_s1)
		+ hfan_pkg::FIFO_CNT_W'(valid_s2);
	assign item_ready = !clr_q && (reserved < hfan_pkg::FIFO_CNT_W'(hfan_pkg::FIFO_DEPTH));
	assign in_acc     = item_valid && item_ready;

	assign xa = XW'(corner_a);
	assign xb = XW'(corner_b);
	assign xc = XW'(corner_c);
	assign xd = XW'(corner_d);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			u_in[k] = DW'($signed(xc[k*COORD_BITS +: COORD_BITS]))
				- DW'($signed(xa[k*COORD_BITS +: COORD_BITS]));
			v_in[k] = DW'($signed(xd[k*COORD_BITS +: COORD_BITS]))
				- DW'($signed(xb[k*COORD_BITS +: COORD_BITS]));
		end
	end

	// the entry written by stage 1 this cycle is read stale by the new request
	assign owned_s1 = mem_rd_s1[MW-1] || fwd_s1;
	assign wr_s1    = valid_s1 && in_range_s1 && !owned_s1;

	// owner table port
	always_ff @(posedge clk) begin
		if (clr_q) begin
			owner_mem[clr_idx_q] <= '0;
		end else if (wr_s1) begin
			owner_mem[idx_s1] <= {1'b1, cell_s1};
		end
		if (in_acc) begin
			mem_rd_s1 <= owner_mem[idx];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
			valid_s1  <= 1'b0;
			fwd_s1    <= 1'b0;
			valid_s2  <= 1'b0;
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			cnt_q     <= '0;
		end else begin
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == FIDX_W'(MAX_FACES - 1)) begin
					clr_q <= 1'b0;
				end
			end
			valid_s1 <= in_acc;
			fwd_s1   <= wr_s1 && (idx_s1 == idx);
			valid_s2 <= wr_s1;
			if (valid_s2) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_acc) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + hfan_pkg::FIFO_CNT_W'(valid_s2)
				- hfan_pkg::FIFO_CNT_W'(out_acc);
		end
	end

	// payload pipeline
	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_range_s1 <= in_range;
			neg_s1      <= (face_slot == '0);
			idx_s1      <= idx;
			fid_s1      <= face_id;
			cell_s1     <= CELL_BITS'(cell_id);
			u_s1        <= u_in;
			v_s1        <= v_in;
		end
		neg_s2  <= neg_s1;
		fid_s2  <= fid_s1;
		p_s2[0] <= u_s1[1] * v_s1[2];
		p_s2[1] <= u_s1[2] * v_s1[1];
		p_s2[2] <= u_s1[2] * v_s1[0];
		p_s2[3] <= u_s1[0] * v_s1[2];
		p_s2[4] <= u_s1[0] * v_s1[1];
		p_s2[5] <= u_s1[1] * v_s1[0];
		if (valid_s2) begin
			fifo_q[wr_ptr_q] <= res_s2;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			n_s2[k] = NW'(p_s2[2*k]) - NW'(p_s2[2*k+1]);
			if (neg_s2) begin
				n_s2[k] = -n_s2[k];
			end
		end
		res_s2.face_id = fid_s2;
		res_s2.nx      = hfan_pkg::NORM_W'(n_s2[0]);
		res_s2.ny      = hfan_pkg::NORM_W'(n_s2[1]);
		res_s2.nz      = hfan_pkg::NORM_W'(n_s2[2]);
	end

	assign result_valid = (cnt_q != '0);
	assign out_acc      = result_valid && result_ready;
	assign out_face_id  = fifo_q[rd_ptr_q].face_id;
	assign normal_x     = fifo_q[rd_ptr_q].nx;
	assign normal_y     = fifo_q[rd_ptr_q].ny;
	assign normal_z     = fifo_q[rd_ptr_q].nz;

endmodule

// ----- verif/hex_face_area_normal_tb.sv -----
// testbench for hex_face_area_normal: ownership and area vector against a local predictor
module hex_face_area_normal_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_W   = 20;
	localparam int N_FACES   = 4096;
	localparam int CMAX      = 2 ** (COORD_W - 1) - 1;
	localparam int CMIN      = -(2 ** (COORD_W - 1));
	localparam int PHASE_LEN = 500;

	typedef struct packed {
		logic [hfan_pkg::CORNER_W-1:0] a;
		logic [hfan_pkg::CORNER_W-1:0] b;
		logic [hfan_pkg::CORNER_W-1:0] c;
		logic [hfan_pkg::CORNER_W-1:0] d;
		logic [hfan_pkg::FACE_W-1:0]   fid;
		logic [hfan_pkg::CELLIN_W-1:0] cell_no;
		logic [hfan_pkg::SLOT_W-1:0]   slot;
	} face_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic result_ready = 1'b0;
	face_req_t held = '0;
	logic item_ready, result_valid;
	logic [hfan_pkg::FACE_W-1:0] out_face_id;
	logic signed [hfan_pkg::NORM_W-1:0] normal_x, normal_y, normal_z;

	face_req_t face_reqs[$];
	hfan_pkg::result_t owed_normals[$];
	bit face_owned [N_FACES];
	logic [hfan_pkg::FACE_W-1:0] used_faces[$];
	int send_idle_pct = 26;
	int take_stall_pct = 87;
	int fault_count = 0;

	hex_face_area_normal uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.corner_a(held.a),
		.corner_b(held.b),
		.corner_c(held.c),
		.corner_d(held.d),
		.face_id(held.fid),
		.cell_id(held.cell_no),
		.face_slot(held.slot),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.out_face_id(out_face_id),
		.normal_x(normal_x),
		.normal_y(normal_y),
		.normal_z(normal_z)
	);

	always #5ns clk = ~clk;

	function automatic longint coord_of(logic [hfan_pkg::CORNER_W-1:0] p, int k);
		logic signed [COORD_W-1:0] v;
		v = p[k*COORD_W +: COORD_W];
		return longint'(v);
	endfunction

	// (c-a)x(d-b), negated for slot 0, wrapped to the output width
	function automatic hfan_pkg::result_t face_area_vector(face_req_t r);
		longint u [3];
		longint v [3];
		longint n [3];
		hfan_pkg::result_t res;
		for (int k = 0; k < 3; k++) begin
			u[k] = coord_of(r.c, k) - coord_of(r.a, k);
			v[k] = coord_of(r.d, k) - coord_of(r.b, k);
		end
		n[0] = u[1] * v[2] - u[2] * v[1];
		n[1] = u[2] * v[0] - u[0] * v[2];
		n[2] = u[0] * v[1] - u[1] * v[0];
		if (r.slot == 0) begin
			for (int k = 0; k < 3; k++)
				n[k] = -n[k];
		end
		res.face_id = r.fid;
		res.nx = hfan_pkg::NORM_W'(n[0]);
		res.ny = hfan_pkg::NORM_W'(n[1]);
		res.nz = hfan_pkg::NORM_W'(n[2]);
		return res;
	endfunction

	function automatic logic [hfan_pkg::CORNER_W-1:0] pack3(int x, int y, int z);
		return {z[COORD_W-1:0], y[COORD_W-1:0], x[COORD_W-1:0]};
	endfunction

	function automatic int rand_coord();
		case ($urandom_range(0, 3))
			0: return CMIN;
			1: return CMAX;
			2: return $urandom_range(0, 1) ? -1 : 0;
			default: return int'($urandom_range(0, 2 * CMAX + 1)) + CMIN;
		endcase
	endfunction

	function automatic logic [hfan_pkg::CORNER_W-1:0] rand_corner();
		case ($urandom_range(0, 3))
			0: return hfan_pkg::CORNER_W'({$urandom, $urandom});
			1: return pack3(rand_coord(), rand_coord(), rand_coord());
			default: return pack3(int'($urandom_range(0, 2047)) - 1024,
				int'($urandom_range(0, 2047)) - 1024, int'($urandom_range(0, 2047)) - 1024);
		endcase
	endfunction

	task automatic queue_face(logic [hfan_pkg::CORNER_W-1:0] a,
			logic [hfan_pkg::CORNER_W-1:0] b,
			logic [hfan_pkg::CORNER_W-1:0] c, logic [hfan_pkg::CORNER_W-1:0] d,
			int fid, int cell_no, int slot);
		face_req_t r;
		r.a = a;
		r.b = b;
		r.c = c;
		r.d = d;
		r.fid = hfan_pkg::FACE_W'(fid);
		r.cell_no = hfan_pkg::CELLIN_W'(cell_no);
		r.slot = hfan_pkg::SLOT_W'(slot);
		face_reqs.push_back(r);
		used_faces.push_back(r.fid);
	endtask

	task automatic queue_random_faces(int count);
		int fid;
		for (int i = 0; i < count; i++) begin
			// a quarter of requests revisit a face already sent
			if (used_faces.size() != 0 && $urandom_range(0, 3) == 0)
				fid = int'(used_faces[$urandom_range(0, used_faces.size() - 1)]);
			else
				fid = $urandom_range(0, N_FACES - 1);
			queue_face(rand_corner(), rand_corner(), rand_corner(), rand_corner(),
				fid, $urandom_range(0, 65535), $urandom_range(0, 7));
		end
	endtask

	task automatic wait_drained();
		while (face_reqs.size() != 0 || item_valid || owed_normals.size() != 0)
			@(negedge clk);
	endtask

	// request side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				if (held.fid < N_FACES && !face_owned[held.fid]) begin
					face_owned[held.fid] = 1'b1;
					owed_normals.push_back(face_area_vector(held));
				end
			end
			if (!item_valid || item_ready) begin
				if (face_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					held <= face_reqs.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// result side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (owed_normals.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("unexpected result: face %0d n=(%0d,%0d,%0d)",
							out_face_id, normal_x, normal_y, normal_z);
				end else begin
					hfan_pkg::result_t want;
					want = owed_normals.pop_front();
					if (out_face_id !== want.face_id || normal_x !== want.nx ||
							normal_y !== want.ny || normal_z !== want.nz) begin
						fault_count++;
						if (fault_count <= 10)
							$display("mismatch: want face %0d n=(%0d,%0d,%0d) %s",
								want.face_id, want.nx, want.ny, want.nz,
								$sformatf("got face %0d n=(%0d,%0d,%0d)",
									out_face_id, normal_x, normal_y, normal_z));
					end
				end
			end
			result_ready <= ($urandom_range(0, 99) >= take_stall_pct);
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: zero face, extreme corners, owned faces, every slot
		queue_face('0, '0, '0, '0, 0, 0, 0);
		queue_face(pack3(CMIN, CMIN, CMAX), pack3(CMIN, CMAX, CMIN),
			pack3(CMAX, CMAX, CMIN), pack3(CMAX, CMIN, CMAX), 4095, 65535, 0);
		queue_face(pack3(CMIN, CMIN, CMAX), pack3(CMIN, CMAX, CMIN),
			pack3(CMAX, CMAX, CMIN), pack3(CMAX, CMIN, CMAX), 1, 1, 1);
		queue_face(pack3(CMAX, CMAX, CMIN), pack3(CMAX, CMIN, CMAX),
			pack3(CMIN, CMIN, CMAX), pack3(CMIN, CMAX, CMIN), 2, 32768, 0);
		queue_face(pack3(CMIN, CMIN, CMIN), pack3(CMIN, CMIN, CMIN),
			pack3(CMAX, CMAX, CMAX), pack3(CMAX, CMAX, CMAX), 3, 77, 4);
		queue_face('1, '0, '0, '1, 4, 65535, 5);
		queue_face(pack3(CMIN, 0, CMAX), pack3(0, CMIN, 0),
			pack3(CMAX, 0, CMIN), pack3(0, CMAX, 0), 2048, 12, 3);
		// already owned faces give nothing
		queue_face(pack3(1, 2, 3), pack3(4, 5, 6), pack3(7, 8, 9), pack3(1, 1, 1), 0, 9, 2);
		queue_face(pack3(CMAX, 0, 0), pack3(0, CMAX, 0), '0, '0, 4095, 0, 0);
		queue_face('1, '1, '0, '0, 1, 65535, 1);
		for (int s = 0; s < 8; s++)
			queue_face(pack3(0, 0, 0), pack3(1024, 0, 0), pack3(1024, 1024, s),
				pack3(0, 1024, -s), 100 + s, 200 + s, s);
		queue_face(pack3(-1, -1, -1), pack3(-1, -1, -1), '0, '0, 4094, 1, 7);

		queue_random_faces(PHASE_LEN);
		wait_drained();

		@(negedge clk);
		send_idle_pct = 87;
		take_stall_pct = 26;
		queue_random_faces(PHASE_LEN);
		wait_drained();

		@(negedge clk);
		send_idle_pct = 0;
		take_stall_pct = 0;
		queue_random_faces(PHASE_LEN);
		wait_drained();

		repeat (20) @(posedge clk);
		if (owed_normals.size() != 0) begin
			fault_count++;
			if (fault_count <= 10)
				$display("%0d results never arrived", owed_normals.size());
		end
		if (fault_count == 0)
			$display("hex_face_area_normal_tb: done, clean");
		else
			$display("hex_face_area_normal_tb: done, errors");
		$finish;
	end

	// covers the table clear after reset plus the slowest idling phase many times over
	initial begin
		#2ms;
		$display("hex_face_area_normal_tb: done, errors");
		$finish;
	end

endmodule

// ----- hex_face_area_normal.f -----
design/hfan_pkg.sv
design/hex_face_area_normal.sv
verif/hex_face_area_normal_tb.sv
